// ===== design/nrmc_pkg.sv =====
// ----------------------------------------------------------------------------
// nrmc_pkg: shared types and constants for the RMC field extractor
// Holds the parser phase codes, the state and result records and the
// character constants of the sentence syntax.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  // default saturation point of the field counter
  localparam int FIELD_LIMIT_DEF = 15;

  localparam int FIELD_W = 4;
  localparam int BYTE_W  = 8;
  localparam int HPOS_W  = 3;

  // sentence syntax characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_C      = 8'h43;

  // index of the status field
  localparam logic [FIELD_W-1:0] STATUS_FIELD = 4'd2;

  // last header position before the body starts
  localparam logic [HPOS_W-1:0] HPOS_LAST = 3'd4;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_A     = 2'd1,
    ST_OTHER = 2'd2
  } status_t;

  typedef struct packed {
    phase_t              phase;
    logic [HPOS_W-1:0]   header_position;
    logic [FIELD_W-1:0]  current_field;
    status_t             status_tracker;
  } nrmc_state_t;

  typedef struct packed {
    logic                emit;
    logic [FIELD_W-1:0]  field_number;
    logic [BYTE_W-1:0]   character;
    logic                end_of_sentence;
    logic                status_valid;
  } nrmc_result_t;

endpackage

// ===== design/nrmc_if.sv =====
// ----------------------------------------------------------------------------
// nrmc_if: stream channels of the RMC field extractor
// Input byte channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nrmc_in_if;
  logic                        valid;
  logic                        ready;
  logic [nrmc_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_out_if;
  logic                         valid;
  logic                         ready;
  logic [nrmc_pkg::FIELD_W-1:0] field_number;
  logic [nrmc_pkg::BYTE_W-1:0]  character;
  logic                         end_of_sentence;
  logic                         status_valid;

  modport source (output valid, output field_number, output character,
                  output end_of_sentence, output status_valid, input ready);
  modport sink   (input valid, input field_number, input character,
                  input end_of_sentence, input status_valid, output ready);
endinterface

// ===== design/nrmc_step.sv =====
// ----------------------------------------------------------------------------
// nrmc_step: per-byte parser update
// Computes the next parser state and the result item for one received byte.
// ----------------------------------------------------------------------------
module nrmc_step #(
  parameter int FIELD_LIMIT = nrmc_pkg::FIELD_LIMIT_DEF
) (
  input  nrmc_pkg::nrmc_state_t               cur,
  input  logic [nrmc_pkg::BYTE_W-1:0]         rx_byte,
  output nrmc_pkg::nrmc_state_t               nxt,
  output nrmc_pkg::nrmc_result_t              res
);

  localparam logic [nrmc_pkg::FIELD_W-1:0] LIMIT = nrmc_pkg::FIELD_W'(FIELD_LIMIT);

  // header position folded into 0..4
  function automatic logic [nrmc_pkg::HPOS_W-1:0] hpos_wrap(
    input logic [nrmc_pkg::HPOS_W-1:0] pos);
    logic [nrmc_pkg::HPOS_W-1:0] w;
    unique case (pos)
      3'd5:    w = 3'd0;
      3'd6:    w = 3'd1;
      3'd7:    w = 3'd2;
      default: w = pos;
    endcase
    return w;
  endfunction

  // expected header character at a position
  function automatic logic [nrmc_pkg::BYTE_W-1:0] header_char(
    input logic [nrmc_pkg::HPOS_W-1:0] pos);
    logic [nrmc_pkg::BYTE_W-1:0] c;
    unique case (pos)
      3'd0:    c = nrmc_pkg::CH_G;
      3'd1:    c = nrmc_pkg::CH_P;
      3'd2:    c = nrmc_pkg::CH_R;
      3'd3:    c = nrmc_pkg::CH_M;
      default: c = nrmc_pkg::CH_C;
    endcase
    return c;
  endfunction

  logic [nrmc_pkg::HPOS_W-1:0] pos;
  logic                        mismatch;
  logic                        is_eol;
  logic                        is_comma;

  assign pos      = hpos_wrap(cur.header_position);
  assign mismatch = (cur.phase == nrmc_pkg::PH_HDR) && (rx_byte != header_char(pos));
  assign is_eol   = (rx_byte == nrmc_pkg::CH_CR) || (rx_byte == nrmc_pkg::CH_LF);
  assign is_comma = (rx_byte == nrmc_pkg::CH_COMMA);

  // next state
  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      nrmc_pkg::PH_WAIT: begin
        if (rx_byte == nrmc_pkg::CH_DOLLAR) begin
          nxt.phase           = nrmc_pkg::PH_HDR;
          nxt.header_position = '0;
        end
      end
      nrmc_pkg::PH_HDR, nrmc_pkg::PH_SKIP: begin
        if (pos == nrmc_pkg::HPOS_LAST) begin
          nxt.phase = (cur.phase == nrmc_pkg::PH_HDR && !mismatch) ?
                      nrmc_pkg::PH_BODY : nrmc_pkg::PH_WAIT;
          nxt.header_position = '0;
          nxt.current_field   = '0;
          nxt.status_tracker  = nrmc_pkg::ST_NONE;
        end else begin
          nxt.phase           = mismatch ? nrmc_pkg::PH_SKIP : cur.phase;
          nxt.header_position = pos + 3'd1;
        end
      end
      default: begin
        priority if (is_eol) begin
          nxt.phase           = nrmc_pkg::PH_WAIT;
          nxt.header_position = '0;
          nxt.current_field   = '0;
          nxt.status_tracker  = nrmc_pkg::ST_NONE;
        end else if (is_comma) begin
          if (cur.current_field < LIMIT) begin
            nxt.current_field = cur.current_field + 4'd1;
          end
        end else if (cur.current_field == nrmc_pkg::STATUS_FIELD) begin
          nxt.status_tracker =
            (cur.status_tracker == nrmc_pkg::ST_NONE && rx_byte == nrmc_pkg::CH_A) ?
            nrmc_pkg::ST_A : nrmc_pkg::ST_OTHER;
        end else begin
          nxt.status_tracker = cur.status_tracker;
        end
      end
    endcase
  end

  // result item
  always_comb begin
    res                 = '0;
    res.field_number    = cur.current_field;
    if (cur.phase == nrmc_pkg::PH_BODY) begin
      priority if (is_eol) begin
        res.emit            = 1'b1;
        res.end_of_sentence = 1'b1;
        res.status_valid    = (cur.status_tracker == nrmc_pkg::ST_A);
      end else if (!is_comma) begin
        res.emit      = 1'b1;
        res.character = rx_byte;
      end else begin
        res.emit = 1'b0;
      end
    end
  end

endmodule

// ===== design/nmea_rmc_field_extractor.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_field_extractor: RMC sentence field extractor
// Output: a result is registered and appears in the cycle after the transfer of the byte causing it.
// Throughput: one byte per cycle unless the output stalls; the parser state updates on every transfer.
// The single output register refills while its item is taken, so input ready
// drops only while a result waits and the sink holds ready low.
// Reset: synchronous active-low rst_n clears the parser to waiting for '$'.
// ----------------------------------------------------------------------------
module nmea_rmc_field_extractor #(
  parameter int FIELD_LIMIT = nrmc_pkg::FIELD_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nrmc_in_if.sink    in_chan,
  nrmc_out_if.source out_chan
);

  // parser state, updated on every input transfer
  nrmc_pkg::nrmc_state_t  state_r;
  nrmc_pkg::nrmc_state_t  state_nxt;
  nrmc_pkg::nrmc_result_t step_res;

  // output register
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [nrmc_pkg::FIELD_W-1:0] field_number_r;
  logic [nrmc_pkg::BYTE_W-1:0]  character_r;
  logic                         end_of_sentence_r;
  logic                         status_valid_r;

  logic in_xfer;
  logic out_xfer;

  // free to load when empty or when the held item leaves this cycle
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_xfer      = out_valid_r && out_chan.ready;

  nrmc_step #(
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_step (
    .cur     (state_r),
    .rx_byte (in_chan.rx_byte),
    .nxt     (state_nxt),
    .res     (step_res)
  );

  // valid bit: set by a transfer that emits, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = step_res.emit;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase           <= nrmc_pkg::PH_WAIT;
      state_r.header_position <= '0;
      state_r.current_field   <= '0;
      state_r.status_tracker  <= nrmc_pkg::ST_NONE;
      out_valid_r             <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload, loaded only by an emitting transfer
  always_ff @(posedge clk) begin
    if (in_xfer && step_res.emit) begin
      field_number_r    <= step_res.field_number;
      character_r       <= step_res.character;
      end_of_sentence_r <= step_res.end_of_sentence;
      status_valid_r    <= step_res.status_valid;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.field_number    = field_number_r;
  assign out_chan.character       = character_r;
  assign out_chan.end_of_sentence = end_of_sentence_r;
  assign out_chan.status_valid    = status_valid_r;

endmodule

// ===== design/nrmc_checker.sv =====
// ----------------------------------------------------------------------------
// nrmc_checker: port-level checks for the RMC field extractor
// Watches the top-level handshakes and result fields over time.
// ----------------------------------------------------------------------------
module nrmc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [nrmc_pkg::FIELD_W-1:0] field_number,
  input logic [nrmc_pkg::BYTE_W-1:0]  character,
  input logic                         end_of_sentence,
  input logic                         status_valid
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(field_number)
      && $stable(character) && $stable(end_of_sentence) && $stable(status_valid))
    else $error("result changed while stalled");

  // a waiting result blocks the input while the sink stalls
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output register full");

  // a rising result valid comes from an input transfer in the previous cycle
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input transfer");

  // end item carries no character
  a_end_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_sentence |-> character == '0)
    else $error("end item with nonzero character");

  // status flag only on end item
  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_valid |-> end_of_sentence)
    else $error("status flag on character item");

endmodule

bind nmea_rmc_field_extractor nrmc_checker u_nrmc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .field_number    (out_chan.field_number),
  .character       (out_chan.character),
  .end_of_sentence (out_chan.end_of_sentence),
  .status_valid    (out_chan.status_valid)
);
